// ----- rtl/core/dfc_pkg.sv -----
// ----------------------------------------------------------------------------
// dfc_pkg
// Shared constants and types of the DHCP frame classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package dfc_pkg;

   localparam int unsigned BOOTP_FIXED_LEN = 240;
   localparam int unsigned MAX_FRAME_LEN   = 2048;

   localparam logic [15:0] SERVER_PORT_RESET = 16'd67;
   localparam logic [15:0] CLIENT_PORT_RESET = 16'd68;

   localparam logic [1:0] CSR_SERVER_PORT = 2'd0;
   localparam logic [1:0] CSR_CLIENT_PORT = 2'd1;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;

   localparam logic [7:0] OPT_PAD      = 8'd0;
   localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
   localparam logic [7:0] OPT_END      = 8'hFF;

   localparam logic [7:0] MSG_TYPE_MIN      = 8'd1;
   localparam logic [7:0] MSG_TYPE_MAX      = 8'd8;
   localparam logic [7:0] MSG_TYPE_DISCOVER = 8'd1;

   localparam logic [3:0] REPLY_NONE  = 4'd0;
   localparam logic [3:0] REPLY_OFFER = 4'd2;
   localparam logic [3:0] REPLY_ACK   = 4'd5;

   localparam logic [1:0] VERDICT_NOT_DHCP = 2'd0;
   localparam logic [1:0] VERDICT_ACCEPT   = 2'd1;
   localparam logic [1:0] VERDICT_INVALID  = 2'd2;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [3:0]  msg_type;
      logic [3:0]  reply_type;
      logic [47:0] client_mac;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/core/dhcp_frame_classifier_core.sv -----
// ----------------------------------------------------------------------------
// dhcp_frame_classifier_core
// Streaming classifier of DHCP requests in received Ethernet frames.
// ----------------------------------------------------------------------------
// Frame bytes enter one beat per cycle on the req channel and the block takes
// a beat in every cycle while the rsp side keeps up. Each beat is registered
// and then folded into a small running parse state; the beat marked last
// yields one rsp beat (verdict, message type, reply type, source MAC) via the
// input and rsp registers. A pending result holds only a final beat behind
// it; non-final beats keep flowing. The user must set ports through the csr
// write port while no frame is in flight; the block does not enforce this.
`default_nettype none

module dhcp_frame_classifier_core
   import dfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_frame_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_verdict,
   output logic [3:0]       rsp_msg_type,
   output logic [3:0]       rsp_reply_type,
   output logic [47:0]      rsp_client_mac,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0] server_port_ff;
   logic [15:0] client_port_ff;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        rsp_valid_ff;
   result_type  rsp_data_ff;
   result_type  result;
   logic        step;

   assign step      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         server_port_ff <= SERVER_PORT_RESET;
         client_port_ff <= CLIENT_PORT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SERVER_PORT: server_port_ff <= csr_wdata;
            CSR_CLIENT_PORT: client_port_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_frame_byte;
         in_last_ff <= req_last_byte;
      end
   end

   dfc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .frame_byte  (in_byte_ff),
      .last_byte   (in_last_ff),
      .server_port (server_port_ff),
      .client_port (client_port_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_verdict    = rsp_data_ff.verdict;
   assign rsp_msg_type   = rsp_data_ff.msg_type;
   assign rsp_reply_type = rsp_data_ff.reply_type;
   assign rsp_client_mac = rsp_data_ff.client_mac;

`ifndef ASSERT_OFF
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_ready
      |=> in_valid_ff && in_last_ff)
      else $error("final beat dropped while result pending");

   a_invalid_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.verdict == VERDICT_INVALID
      |-> rsp_data_ff.msg_type == 4'd0 && rsp_data_ff.reply_type == REPLY_NONE)
      else $error("invalid verdict carries a message type");

   a_reject_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.verdict == VERDICT_NOT_DHCP
      |-> rsp_data_ff.client_mac == 48'd0 && rsp_data_ff.reply_type == REPLY_NONE)
      else $error("rejected frame carries result fields");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/dfc_parser.sv -----
// ----------------------------------------------------------------------------
// dfc_parser
// Running parse state of one frame and the verdict on its final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dfc_parser
   import dfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [7:0]  frame_byte,
   input  wire logic        last_byte,
   input  wire logic [15:0] server_port,
   input  wire logic [15:0] client_port,
   output result_type       result
);

   localparam logic [2:0] PH_HDR   = 3'd0;
   localparam logic [2:0] PH_CODE  = 3'd1;
   localparam logic [2:0] PH_LEN   = 3'd2;
   localparam logic [2:0] PH_SKIP  = 3'd3;
   localparam logic [2:0] PH_LEN53 = 3'd4;
   localparam logic [2:0] PH_TYPE  = 3'd5;
   localparam logic [2:0] PH_DONE  = 3'd6;

   localparam logic [15:0] OPT_OFFSET = 16'(8 + BOOTP_FIXED_LEN);
   localparam logic [15:0] MAX_LEN    = 16'(MAX_FRAME_LEN);

   logic [15:0] pos_ff, pos_in;
   logic [5:0]  hlen_ff, hlen_in;
   logic [7:0]  shift_ff, shift_in;
   logic [47:0] mac_ff, mac_in;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  skip_ff, skip_in;
   logic [7:0]  type_ff, type_in;
   logic        reject_ff, reject_in;
   logic        found_ff, found_in;

   logic [15:0] udp_at;
   logic [15:0] opt_at;
   logic [16:0] frame_len;
   logic        frame_ok;
   logic        type_valid;

   always_comb begin
      pos_in    = (pos_ff != 16'hFFFF) ? pos_ff + 16'd1 : pos_ff;
      hlen_in   = hlen_ff;
      shift_in  = shift_ff;
      mac_in    = mac_ff;
      phase_in  = phase_ff;
      skip_in   = skip_ff;
      type_in   = type_ff;
      reject_in = reject_ff;
      found_in  = found_ff;

      if (pos_ff >= MAX_LEN) begin
         reject_in = 1'b1;
      end
      if (pos_ff >= 16'd6 && pos_ff < 16'd12) begin
         mac_in = {mac_ff[39:0], frame_byte};
      end
      if (pos_ff == 16'd12) begin
         shift_in = frame_byte;
      end
      if (pos_ff == 16'd13 && {shift_ff, frame_byte} != ETHERTYPE_IPV4) begin
         reject_in = 1'b1;
      end
      if (pos_ff == 16'd14) begin
         hlen_in = {frame_byte[3:0], 2'b00};
      end
      if (pos_ff == 16'd23 && frame_byte != IP_PROTO_UDP) begin
         reject_in = 1'b1;
      end

      udp_at = 16'd14 + {10'd0, hlen_in};
      opt_at = udp_at + OPT_OFFSET;

      if (pos_ff >= 16'd14) begin
         if (pos_ff == udp_at || pos_ff == udp_at + 16'd2) begin
            shift_in = frame_byte;
         end
         if (pos_ff == udp_at + 16'd1 && {shift_ff, frame_byte} != client_port) begin
            reject_in = 1'b1;
         end
         if (pos_ff == udp_at + 16'd3 && {shift_ff, frame_byte} != server_port) begin
            reject_in = 1'b1;
         end
      end

      if (phase_ff == PH_HDR && pos_ff >= 16'd14 && pos_ff == opt_at) begin
         phase_in = PH_CODE;
      end

      case (phase_in)
         PH_CODE: begin
            if (frame_byte == OPT_MSG_TYPE) begin
               phase_in = PH_LEN53;
            end else if (frame_byte == OPT_END) begin
               phase_in = PH_DONE;
            end else if (frame_byte != OPT_PAD) begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            skip_in  = frame_byte;
            phase_in = (frame_byte != 8'd0) ? PH_SKIP : PH_CODE;
         end
         PH_SKIP: begin
            skip_in = skip_ff - 8'd1;
            if (skip_in == 8'd0) begin
               phase_in = PH_CODE;
            end
         end
         PH_LEN53: begin
            phase_in = PH_TYPE;
         end
         PH_TYPE: begin
            type_in  = frame_byte;
            found_in = 1'b1;
            phase_in = PH_DONE;
         end
         default: begin
         end
      endcase

      frame_len  = {1'b0, pos_ff} + 17'd1;
      frame_ok   = !reject_in && frame_len >= 17'd34 &&
                   frame_len >= {1'b0, udp_at} + 17'd4;
      type_valid = type_in >= MSG_TYPE_MIN && type_in <= MSG_TYPE_MAX;

      result = '0;
      if (frame_ok) begin
         result.client_mac = mac_in;
         if (!found_in) begin
            result.verdict    = VERDICT_ACCEPT;
            result.reply_type = REPLY_ACK;
         end else if (type_valid) begin
            result.verdict    = VERDICT_ACCEPT;
            result.msg_type   = type_in[3:0];
            result.reply_type = (type_in == MSG_TYPE_DISCOVER) ? REPLY_OFFER : REPLY_ACK;
         end else begin
            result.verdict = VERDICT_INVALID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         hlen_ff   <= '0;
         shift_ff  <= '0;
         mac_ff    <= '0;
         phase_ff  <= PH_HDR;
         skip_ff   <= '0;
         type_ff   <= '0;
         reject_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else if (step) begin
         if (last_byte) begin
            pos_ff    <= '0;
            hlen_ff   <= '0;
            shift_ff  <= '0;
            mac_ff    <= '0;
            phase_ff  <= PH_HDR;
            skip_ff   <= '0;
            type_ff   <= '0;
            reject_ff <= 1'b0;
            found_ff  <= 1'b0;
         end else begin
            pos_ff    <= pos_in;
            hlen_ff   <= hlen_in;
            shift_ff  <= shift_in;
            mac_ff    <= mac_in;
            phase_ff  <= phase_in;
            skip_ff   <= skip_in;
            type_ff   <= type_in;
            reject_ff <= reject_in;
            found_ff  <= found_in;
         end
      end
   end

`ifndef ASSERT_OFF
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && last_byte |=> pos_ff == 16'd0 && phase_ff == PH_HDR && !found_ff)
      else $error("frame state not cleared after final beat");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != 8'd0)
      else $error("option skip with empty count");

   a_found_done: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> phase_ff == PH_DONE)
      else $error("message type found while still walking options");
`endif

endmodule

`default_nettype wire
